/* src/mda_pkg.sv */
`default_nettype none

package mda_pkg;

   localparam int MAX_FRAMES = 256;
   localparam int MAX_SPAN   = 1024;
   localparam int IDX_W      = $clog2(MAX_FRAMES);
   localparam int FC_W       = IDX_W + 1;
   localparam int SPAN_W     = $clog2(MAX_SPAN) + 1;
   localparam int TIME_W     = 32;
   localparam int RATE_W     = 24;
   localparam int POS_W      = TIME_W + RATE_W - 16;
   localparam int PINT_W     = POS_W - 16;
   localparam int FNUM_W     = PINT_W + 1;
   localparam int STEP_W     = $clog2(FNUM_W);

   localparam logic [RATE_W-1:0] RATE_RESET  = 24'd1966080;
   localparam logic [FC_W-1:0]   COUNT_RESET = 9'd1;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   localparam logic CSR_FRAME_RATE  = 1'b0;
   localparam logic CSR_FRAME_COUNT = 1'b1;

   typedef struct packed {
      logic               action;
      logic [7:0]         frame_index;
      logic signed [31:0] delta_x;
      logic signed [31:0] delta_y;
      logic signed [31:0] delta_z;
      logic [31:0]        time_start;
      logic [31:0]        time_end;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sum_x;
      logic signed [31:0] sum_y;
      logic signed [31:0] sum_z;
      logic               span_overflow;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POS,
      ST_SETUP,
      ST_MOD,
      ST_WALK,
      ST_TAIL_RD,
      ST_TAIL_MUL,
      ST_TAIL_ADD,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic load_wr;
      logic pos_en;
      logic setup_en;
      logic mod_step;
      logic walk_step;
      logic tail_rd;
      logic tail_mul;
      logic tail_add;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [SPAN_W-1:0] walk_len;
      logic              rsp_busy;
   } sts_type;

endpackage

`default_nettype wire

/* src/motion_delta_accumulator_unit.sv */
`default_nettype none

// Motion delta accumulator. A load transaction (action 0) writes one x/y/z
// delta triple into a 256-entry frame table. A query transaction (action 1)
// converts both times to frame positions with the programmed frame rate, sums
// the whole frames between them with wrap-around at frame_count, and adds the
// weighted end frame; the whole frames walked number at most 1024, with
// span_overflow set when cut. Frame numbers are mapped onto the table by a
// 25-step bit-serial remainder, and the walk reads the single table read port
// one frame per cycle. The frame table holds no valid bits: querying a slot
// never loaded returns undefined data. Write csr registers only while no query
// is in flight.
module motion_delta_accumulator_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire mda_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output mda_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic             csr_index,
   input  wire logic [23:0]      csr_data
);

   mda_pkg::cmd_type cmd;
   mda_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   mda_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_ready  (req_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mda_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> rsp_valid)
      else $error("result register not loaded");

   a_walk_len: assert property (@(posedge clock) disable iff (reset)
      cmd.mod_step |-> sts.walk_len <= mda_pkg::SPAN_W'(mda_pkg::MAX_SPAN))
      else $error("walk length above span limit");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.action == mda_pkg::ACT_QUERY) |=> !req_ready)
      else $error("query not held busy");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.pos_en, cmd.setup_en, cmd.mod_step, cmd.walk_step, cmd.tail_rd,
                cmd.tail_mul, cmd.tail_add, cmd.rsp_load}))
      else $error("conflicting datapath commands");
`endif

endmodule

`default_nettype wire

/* src/mda_ctrl.sv */
`default_nettype none

module mda_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_action,
   output logic                  req_ready,
   input  wire mda_pkg::sts_type sts,
   output mda_pkg::cmd_type      cmd
);

   mda_pkg::state_type state_ff, state_in;
   logic [mda_pkg::STEP_W-1:0] mod_cnt_ff, mod_cnt_in;
   logic [mda_pkg::SPAN_W-1:0] walk_cnt_ff, walk_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= mda_pkg::ST_IDLE;
         mod_cnt_ff  <= '0;
         walk_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         mod_cnt_ff  <= mod_cnt_in;
         walk_cnt_ff <= walk_cnt_in;
      end
   end

   // next state and counters
   always_comb begin
      state_in    = state_ff;
      mod_cnt_in  = mod_cnt_ff;
      walk_cnt_in = walk_cnt_ff;
      unique case (state_ff)
         mda_pkg::ST_IDLE: begin
            if (req_valid && req_action == mda_pkg::ACT_QUERY) state_in = mda_pkg::ST_POS;
         end
         mda_pkg::ST_POS: begin
            state_in = mda_pkg::ST_SETUP;
         end
         mda_pkg::ST_SETUP: begin
            mod_cnt_in = mda_pkg::STEP_W'(mda_pkg::FNUM_W - 1);
            state_in   = mda_pkg::ST_MOD;
         end
         mda_pkg::ST_MOD: begin
            mod_cnt_in = mod_cnt_ff - 1'b1;
            if (mod_cnt_ff == '0) begin
               walk_cnt_in = sts.walk_len;
               state_in    = (sts.walk_len == '0) ? mda_pkg::ST_TAIL_RD : mda_pkg::ST_WALK;
            end
         end
         mda_pkg::ST_WALK: begin
            walk_cnt_in = walk_cnt_ff - 1'b1;
            if (walk_cnt_ff == mda_pkg::SPAN_W'(1)) state_in = mda_pkg::ST_TAIL_RD;
         end
         mda_pkg::ST_TAIL_RD: begin
            state_in = mda_pkg::ST_TAIL_MUL;
         end
         mda_pkg::ST_TAIL_MUL: begin
            state_in = mda_pkg::ST_TAIL_ADD;
         end
         mda_pkg::ST_TAIL_ADD: begin
            state_in = mda_pkg::ST_FINISH;
         end
         mda_pkg::ST_FINISH: begin
            if (!sts.rsp_busy) state_in = mda_pkg::ST_IDLE;
         end
         default: begin
            state_in = mda_pkg::ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         mda_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid && req_action == mda_pkg::ACT_QUERY;
            cmd.load_wr = req_valid && req_action == mda_pkg::ACT_LOAD;
         end
         mda_pkg::ST_POS:      cmd.pos_en    = 1'b1;
         mda_pkg::ST_SETUP:    cmd.setup_en  = 1'b1;
         mda_pkg::ST_MOD:      cmd.mod_step  = 1'b1;
         mda_pkg::ST_WALK:     cmd.walk_step = 1'b1;
         mda_pkg::ST_TAIL_RD:  cmd.tail_rd   = 1'b1;
         mda_pkg::ST_TAIL_MUL: cmd.tail_mul  = 1'b1;
         mda_pkg::ST_TAIL_ADD: cmd.tail_add  = 1'b1;
         mda_pkg::ST_FINISH:   cmd.rsp_load  = !sts.rsp_busy;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* src/mda_datapath.sv */
`default_nettype none

module mda_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire mda_pkg::req_type req_data,
   input  wire mda_pkg::cmd_type cmd,
   output mda_pkg::sts_type      sts,
   input  wire logic             csr_valid,
   input  wire logic             csr_index,
   input  wire logic [23:0]      csr_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output mda_pkg::rsp_type      rsp_data
);

   localparam int IW = mda_pkg::IDX_W;
   localparam int FW = mda_pkg::FC_W;

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [32:0] b);
      logic signed [33:0] s;
      s = {{2{a[31]}}, a} + {b[32], b};
      if (s[33:31] == 3'b000 || s[33:31] == 3'b111) return s[31:0];
      return s[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
   endfunction

   function automatic logic signed [32:0] scale_term(input logic signed [48:0] p);
      // divide by 2^16, rounding toward zero
      return p[48:16] + ((p[48] && p[15:0] != '0) ? 33'sd1 : 33'sd0);
   endfunction

   function automatic logic signed [31:0] dead_zone(input logic signed [31:0] v);
      if (v >= -32'sd65 && v <= 32'sd65) return '0;
      return v;
   endfunction

   // configuration
   logic [mda_pkg::RATE_W-1:0] rate_ff;
   logic [FW-1:0]              count_ff;
   logic [FW-1:0]              fc;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff  <= mda_pkg::RATE_RESET;
         count_ff <= mda_pkg::COUNT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            mda_pkg::CSR_FRAME_RATE:  rate_ff  <= csr_data;
            mda_pkg::CSR_FRAME_COUNT: count_ff <= csr_data[FW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (count_ff == '0) fc = FW'(1);
      else if (count_ff > FW'(mda_pkg::MAX_FRAMES)) fc = FW'(mda_pkg::MAX_FRAMES);
      else fc = count_ff;
   end

   // delta stores
   logic [31:0] mem_x [mda_pkg::MAX_FRAMES];
   logic [31:0] mem_y [mda_pkg::MAX_FRAMES];
   logic [31:0] mem_z [mda_pkg::MAX_FRAMES];
   logic [31:0] rd_x_ff, rd_y_ff, rd_z_ff;
   logic [IW-1:0] rd_addr;
   logic [IW-1:0] rem1_ff, rem2_ff;

   assign rd_addr = cmd.tail_rd ? rem2_ff : rem1_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         mem_x[req_data.frame_index[IW-1:0]] <= req_data.delta_x;
         mem_y[req_data.frame_index[IW-1:0]] <= req_data.delta_y;
         mem_z[req_data.frame_index[IW-1:0]] <= req_data.delta_z;
      end
      if (cmd.walk_step || cmd.tail_rd) begin
         rd_x_ff <= mem_x[rd_addr];
         rd_y_ff <= mem_y[rd_addr];
         rd_z_ff <= mem_z[rd_addr];
      end
   end

   // positions
   logic [31:0]                 t1_ff, t2_ff;
   logic [mda_pkg::POS_W-1:0]   pos1_ff, pos2_ff;
   logic [55:0]                 prod1, prod2;

   assign prod1 = 56'(t1_ff) * 56'(rate_ff);
   assign prod2 = 56'(t2_ff) * 56'(rate_ff);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         t1_ff <= req_data.time_start;
         t2_ff <= req_data.time_end;
      end
      if (cmd.pos_en) begin
         pos1_ff <= prod1[55:16];
         pos2_ff <= prod2[55:16];
      end
   end

   // setup: frame numbers, walk length, weight
   logic [mda_pkg::PINT_W-1:0] pint1, pint2, walk_raw;
   logic [15:0]                frac1, frac2;
   logic                       start_lt_end;
   logic                       too_long;
   logic [mda_pkg::FNUM_W-1:0] n1_sh_ff, n2_sh_ff;
   logic [mda_pkg::SPAN_W-1:0] walk_len_ff;
   logic                       over_ff;
   logic signed [16:0]         weight_ff;

   assign pint1        = pos1_ff[mda_pkg::POS_W-1:16];
   assign pint2        = pos2_ff[mda_pkg::POS_W-1:16];
   assign frac1        = pos1_ff[15:0];
   assign frac2        = pos2_ff[15:0];
   assign start_lt_end = pint1 < pint2;
   assign walk_raw     = pint2 - pint1;
   assign too_long     = start_lt_end && walk_raw > mda_pkg::PINT_W'(mda_pkg::MAX_SPAN);

   // remainder lanes, one bit of each frame number per step
   logic [FW-1:0] t1_rem, t2_rem, r1, r2, walk_nxt;

   assign t1_rem   = {rem1_ff, n1_sh_ff[mda_pkg::FNUM_W-1]};
   assign t2_rem   = {rem2_ff, n2_sh_ff[mda_pkg::FNUM_W-1]};
   assign r1       = (t1_rem >= fc) ? t1_rem - fc : t1_rem;
   assign r2       = (t2_rem >= fc) ? t2_rem - fc : t2_rem;
   assign walk_nxt = {1'b0, rem1_ff} + FW'(1);

   always_ff @(posedge clock) begin
      if (cmd.setup_en) begin
         n1_sh_ff  <= {1'b0, pint1} + mda_pkg::FNUM_W'(1);
         n2_sh_ff  <= {1'b0, pint2} + mda_pkg::FNUM_W'(1);
         rem1_ff   <= '0;
         rem2_ff   <= '0;
         over_ff   <= too_long;
         weight_ff <= start_lt_end ? $signed({1'b0, frac2})
                                   : $signed({1'b0, frac2}) - $signed({1'b0, frac1});
         if (!start_lt_end) walk_len_ff <= '0;
         else if (too_long) walk_len_ff <= mda_pkg::SPAN_W'(mda_pkg::MAX_SPAN);
         else walk_len_ff <= walk_raw[mda_pkg::SPAN_W-1:0];
      end else if (cmd.mod_step) begin
         n1_sh_ff <= n1_sh_ff << 1;
         n2_sh_ff <= n2_sh_ff << 1;
         rem1_ff  <= r1[IW-1:0];
         rem2_ff  <= r2[IW-1:0];
      end else if (cmd.walk_step) begin
         rem1_ff <= (walk_nxt == fc) ? '0 : walk_nxt[IW-1:0];
      end
   end

   // accumulation
   logic               acc_pend_ff;
   logic signed [31:0] sx_ff, sy_ff, sz_ff;
   logic signed [48:0] px_ff, py_ff, pz_ff;

   always_ff @(posedge clock) begin
      if (reset) acc_pend_ff <= 1'b0;
      else acc_pend_ff <= cmd.walk_step;
   end

   always_ff @(posedge clock) begin
      if (cmd.setup_en) begin
         sx_ff <= '0;
         sy_ff <= '0;
         sz_ff <= '0;
      end else if (acc_pend_ff) begin
         sx_ff <= sat_add(sx_ff, {rd_x_ff[31], rd_x_ff});
         sy_ff <= sat_add(sy_ff, {rd_y_ff[31], rd_y_ff});
         sz_ff <= sat_add(sz_ff, {rd_z_ff[31], rd_z_ff});
      end else if (cmd.tail_add) begin
         sx_ff <= sat_add(sx_ff, scale_term(px_ff));
         sy_ff <= sat_add(sy_ff, scale_term(py_ff));
         sz_ff <= sat_add(sz_ff, scale_term(pz_ff));
      end
      if (cmd.tail_mul) begin
         px_ff <= $signed(rd_x_ff) * weight_ff;
         py_ff <= $signed(rd_y_ff) * weight_ff;
         pz_ff <= $signed(rd_z_ff) * weight_ff;
      end
   end

   // result register
   logic             rsp_valid_ff;
   mda_pkg::rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.rsp_load) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.sum_x         <= dead_zone(sx_ff);
         rsp_ff.sum_y         <= dead_zone(sy_ff);
         rsp_ff.sum_z         <= dead_zone(sz_ff);
         rsp_ff.span_overflow <= over_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;
   assign sts.walk_len = walk_len_ff;
   assign sts.rsp_busy = rsp_valid_ff && !rsp_ready;

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import mda_pkg::*;

   localparam longint SUM_MAX   = 2147483647;
   localparam longint SUM_MIN   = -SUM_MAX - 1;
   localparam longint DEAD_BAND = 65;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_FRAME_RATE;
   logic [23:0] csr_data  = '0;

   // shadow of the block: registers and frame table
   logic [23:0] rate_cfg  = RATE_RESET;
   logic [8:0]  count_cfg = COUNT_RESET;
   int          frame_delta [3][256];

   bit          slot_filled [256];
   req_type     req_backlog [$];
   rsp_type     expected_sums [$];
   int          pushed_count   = 0;
   int          taken_count    = 0;
   int          mismatch_count = 0;
   bit          idle_on        = 1'b1;
   int          send_hold      = 0;
   int          stall_left     = 0;

   motion_delta_accumulator_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   function automatic longint sat32(input longint v);
      if (v > SUM_MAX) return SUM_MAX;
      if (v < SUM_MIN) return SUM_MIN;
      return v;
   endfunction

   function automatic int live_frames();
      if (count_cfg == 0) return 1;
      if (count_cfg > 256) return 256;
      return count_cfg;
   endfunction

   // Loads update the frame table; queries return 1 with the accumulated motion.
   function automatic bit apply_motion_item(input req_type r, output rsp_type s);
      longint unsigned fc, p_start, p_end, n_start, n_end, steps, idx, i;
      longint          f_start, f_end, weight;
      longint          acc [3];
      bit              cut;
      int              c;
      s   = '0;
      cut = 1'b0;
      if (r.action == ACT_LOAD) begin
         frame_delta[0][r.frame_index] = r.delta_x;
         frame_delta[1][r.frame_index] = r.delta_y;
         frame_delta[2][r.frame_index] = r.delta_z;
         return 1'b0;
      end
      fc      = live_frames();
      p_start = r.time_start;
      p_end   = r.time_end;
      p_start = (p_start * rate_cfg) >> 16;
      p_end   = (p_end * rate_cfg) >> 16;
      n_start = (p_start >> 16) + 1;
      n_end   = (p_end >> 16) + 1;
      f_start = p_start & 64'hFFFF;
      f_end   = p_end & 64'hFFFF;
      for (c = 0; c < 3; c++) acc[c] = 0;
      if (n_start < n_end) begin
         steps = n_end - n_start;
         if (steps > MAX_SPAN) begin
            steps = MAX_SPAN;
            cut   = 1'b1;
         end
         for (i = 0; i < steps; i++) begin
            idx = (n_start + i) % fc;
            for (c = 0; c < 3; c++) acc[c] = sat32(acc[c] + frame_delta[c][idx]);
         end
         weight = f_end;
      end else begin
         weight = f_end - f_start;
      end
      idx = n_end % fc;
      for (c = 0; c < 3; c++) begin
         acc[c] = sat32(acc[c] + (longint'(frame_delta[c][idx]) * weight) / 65536);
         if (acc[c] >= -DEAD_BAND && acc[c] <= DEAD_BAND) acc[c] = 0;
      end
      s.sum_x         = 32'(acc[0]);
      s.sum_y         = 32'(acc[1]);
      s.sum_z         = 32'(acc[2]);
      s.span_overflow = cut;
      return 1'b1;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idle_on || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] rand_delta();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return $urandom;
      if (r < 8) return $urandom_range(0, 2 << 20) - (1 << 20);
      return $urandom_range(0, 400) - 200;
   endfunction

   // unused fields carry random content
   function automatic req_type fresh_item(input logic act);
      req_type it;
      it.action      = act;
      it.frame_index = 8'($urandom);
      it.delta_x     = $urandom;
      it.delta_y     = $urandom;
      it.delta_z     = $urandom;
      it.time_start  = $urandom;
      it.time_end    = $urandom;
      return it;
   endfunction

   function automatic req_type load_item(input logic [7:0] slot, input logic [31:0] dx,
                                         input logic [31:0] dy, input logic [31:0] dz);
      req_type it;
      it             = fresh_item(ACT_LOAD);
      it.frame_index = slot;
      it.delta_x     = dx;
      it.delta_y     = dy;
      it.delta_z     = dz;
      return it;
   endfunction

   function automatic req_type query_item(input logic [31:0] ts, input logic [31:0] te);
      req_type it;
      it            = fresh_item(ACT_QUERY);
      it.time_start = ts;
      it.time_end   = te;
      return it;
   endfunction

   // Mostly short walks sized in frames at the current rate; a few near the span
   // limit, a few fully random, some with the times reversed.
   function automatic req_type random_query();
      logic [31:0]     t0, t1;
      longint unsigned frames, dt, stop;
      int              pick;
      pick = $urandom_range(0, 19);
      t0   = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 20);
      if (pick < 2) return query_item($urandom, $urandom);
      frames = (pick == 2) ? $urandom_range(1018, 1030) : $urandom_range(0, 40);
      if (rate_cfg == 0) dt = $urandom_range(0, 1 << 20);
      else dt = ((frames << 32) | $urandom) / rate_cfg;
      stop = t0 + dt;
      t1   = (stop > 64'hFFFFFFFF) ? 32'hFFFFFFFF : 32'(stop);
      if (pick < 6) return query_item(t1, t0);
      return query_item(t0, t1);
   endfunction

   task automatic issue(input req_type it);
      if (it.action == ACT_LOAD) slot_filled[it.frame_index] = 1'b1;
      req_backlog.push_back(it);
      pushed_count++;
   endtask

   // hold off until the block is idle and every result is back
   task automatic settle();
      while (taken_count != pushed_count || expected_sums.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [23:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_FRAME_RATE) rate_cfg = value;
      else count_cfg = value[8:0];
   endtask

   task automatic run_phase(input logic [23:0] rate, input logic [8:0] count, input int n);
      int k;
      settle();
      write_reg(CSR_FRAME_RATE, rate);
      write_reg(CSR_FRAME_COUNT, {15'b0, count});
      // every slot a query can reach must be loaded first
      for (k = 0; k < live_frames(); k++)
         if (!slot_filled[k]) issue(load_item(8'(k), rand_delta(), rand_delta(), rand_delta()));
      for (k = 0; k < n; k++) begin
         if (k % 40 == 0) idle_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) < 3)
            issue(load_item(8'($urandom_range(0, 255)), rand_delta(), rand_delta(),
                            rand_delta()));
         else
            issue(random_query());
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_hold <= 0;
      end else if (!req_valid || req_ready) begin
         if (send_hold != 0) begin
            req_valid <= 1'b0;
            send_hold <= send_hold - 1;
         end else if (req_backlog.size() != 0) begin
            req_valid <= 1'b1;
            req_data  <= req_backlog.pop_front();
            send_hold <= pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
   end

   task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset) begin
         // check the result first: it always belongs to an older transaction
         if (rsp_valid && rsp_ready) begin
            if (expected_sums.size() == 0) begin
               $display("%0t unexpected result: expected none actual %h", $time, rsp_data);
               mismatch_count++;
            end else begin
               want = expected_sums.pop_front();
               flag_field("sum_x", want.sum_x, rsp_data.sum_x);
               flag_field("sum_y", want.sum_y, rsp_data.sum_y);
               flag_field("sum_z", want.sum_z, rsp_data.sum_z);
               flag_field("span_overflow", want.span_overflow, rsp_data.span_overflow);
            end
         end
         if (req_valid && req_ready) begin
            taken_count++;
            if (apply_motion_item(req_data, want)) expected_sums.push_back(want);
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: 30 fps, one frame, so every query reads slot 0
      issue(load_item(8'd0, 32'h7FFFFFFF, 32'h80000000, 32'h00000001));
      issue(load_item(8'd255, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF));
      issue(query_item(32'h0, 32'h0));
      issue(query_item(32'h0, 32'hFFFFFFFF));
      issue(query_item(32'hFFFFFFFF, 32'hFFFFFFFF));
      issue(query_item(32'hFFFFFFFF, 32'h0));
      issue(query_item(32'h800, 32'h1000));
      issue(query_item(32'h1000, 32'h800));
      issue(query_item(32'h100, 32'h200));
      // one whole frame plus a tiny weight: edges of the dead band
      issue(load_item(8'd0, 32'd65, -32'sd65, 32'd66));
      issue(query_item(32'h0, 32'd2185));
      issue(load_item(8'd0, -32'sd66, 32'd0, 32'd64));
      issue(query_item(32'h0, 32'd2185));
      issue(load_item(8'd0, 32'd1234567, -32'sd7654321, 32'd3));
      issue(query_item(32'h1000, 32'h800));
      // walks of exactly the span limit and one frame past it
      issue(query_item(32'h0, 32'd2236963));
      issue(query_item(32'h0, 32'd2239147));

      run_phase(24'd0, 9'd0, 20);
      run_phase(24'd1, 9'd2, 40);
      run_phase(24'hFFFFFF, 9'd256, 40);
      run_phase(24'd3932160, 9'd7, 40);
      run_phase(24'($urandom_range(1, 24'hFFFFFF)), 9'd511, 30);
      run_phase(24'($urandom_range(1, 24'hFFFFFF)), 9'($urandom_range(1, 256)), 40);
      run_phase(RATE_RESET, 9'd3, 30);

      while (taken_count != pushed_count || expected_sums.size() != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
      if (mismatch_count == 0 && expected_sums.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #(64'd80_000_000);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

/* filelist.f */
src/mda_pkg.sv
src/mda_ctrl.sv
src/mda_datapath.sv
src/motion_delta_accumulator_unit.sv
verif/tb_top.sv
